/* sv/tdpt_pkg.sv */
package tdpt_pkg;

  // Status that the remainder unit reports back to the sequencer.
  typedef struct packed {
    logic done;      // one-cycle pulse: the remainder is ready
    logic rem_zero;  // the remainder of the finished division is zero
  } div_status_t;

  // Start value of the trial divisor and its square.
  localparam int unsigned FirstDivisor = 3;
  localparam int unsigned FirstSquare  = 9;

endpackage

/* sv/tdpt_div.sv */
module tdpt_div #(
  parameter int DATA_WIDTH = 32,
  parameter int DIV_WIDTH  = DATA_WIDTH / 2 + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DATA_WIDTH-1:0]  dividend,
  input  logic [DIV_WIDTH-1:0]   divisor,
  output tdpt_pkg::div_status_t  status
);
  import tdpt_pkg::*;

  localparam int CntWidth = $clog2(DATA_WIDTH + 1);

  logic [DIV_WIDTH-1:0]  rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] shift_r, shift_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_WIDTH:0]    trial;
  logic [DIV_WIDTH:0]    diff;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  assign trial = {rem_r, shift_r[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt   = rem_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[DIV_WIDTH-1:0];
      end else begin
        rem_nxt = trial[DIV_WIDTH-1:0];
      end
      shift_nxt = {shift_r[DATA_WIDTH-2:0], 1'b0};
      cnt_nxt   = cnt_r - CntWidth'(1);
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      rem_nxt   = '0;
      shift_nxt = dividend;
      cnt_nxt   = CntWidth'(DATA_WIDTH);
      busy_nxt  = 1'b1;
    end
  end

  // Control state is reset; the datapath registers are loaded on start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    shift_r <= shift_nxt;
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

/* sv/trial_division_prime_test.sv */
// Trial-division primality test.
// Input channel: in_valid, in_stall, in_candidate (signed). A transfer happens
// when in_valid is high and in_stall is low. Result channel: out_valid,
// out_stall, out_prime_flag, one result for every input transfer, in order.
// Negative values, zero and one give 0, two gives 1, other even values give 0;
// for each of these the sequencer goes straight to its output state, with no division.
// An odd value v above 2 is divided by 3, 5, 7, ... while the divisor squared
// does not exceed v. Each divisor goes through the shared one-bit-per-cycle
// restoring remainder unit, which is the only divider.
// One item is worked on at a time; in_stall is high from the cycle after an
// input transfer until the result has moved into the output register.
// A result waiting in the output register while out_stall is high does not
// block the next input transfer; that item then waits until the register frees.
// Reset (rst_n low, synchronous) drops out_valid and returns the sequencer to idle.
module trial_division_prime_test #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_candidate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_prime_flag
);
  import tdpt_pkg::*;

  localparam int DivWidth = DATA_WIDTH / 2 + 2;
  localparam int SqWidth  = DATA_WIDTH + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic [DivWidth-1:0]   div_r, div_nxt;
  logic [SqWidth-1:0]    sq_r, sq_nxt;
  logic                  flag_r, flag_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_flag_r, out_flag_nxt;
  logic                  div_start;
  div_status_t           div_st;
  logic                  in_xfer;
  logic                  sq_over;

  assign in_xfer = in_valid && (state_r == S_IDLE);
  assign sq_over = sq_r > {1'b0, value_r};

  // Sequencer: classify the candidate, then walk the odd divisors.
  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          value_nxt = in_candidate;
          div_nxt   = DivWidth'(FirstDivisor);
          sq_nxt    = SqWidth'(FirstSquare);
          if (in_candidate[DATA_WIDTH-1] || (in_candidate <= 1) || !in_candidate[0]) begin
            flag_nxt  = (in_candidate == 2);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (sq_over) begin
          flag_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          if (div_st.rem_zero) begin
            flag_nxt  = 1'b0;
            state_nxt = S_OUT;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            div_nxt   = div_r + DivWidth'(2);
            sq_nxt    = sq_r + SqWidth'({div_r, 2'b00}) + SqWidth'(4);
            state_nxt = S_TEST;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    div_r      <= div_nxt;
    sq_r       <= sq_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // Shared remainder unit.
  tdpt_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .DIV_WIDTH  (DivWidth)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (value_r),
    .divisor  (div_r),
    .status   (div_st)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_prime_flag = out_flag_r;

endmodule

/* sv/tdpt_check.sv */
module tdpt_check #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [DATA_WIDTH-1:0] in_candidate,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_prime_flag
);

  // A stalled input holds its candidate.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> $stable(in_candidate))
    else $error("stalled input changed");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime_flag))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes an input.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input side not busy after a transfer");

  // A new result only appears while an item is in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind trial_division_prime_test tdpt_check #(
  .DATA_WIDTH (DATA_WIDTH)
) u_tdpt_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_candidate   (in_candidate),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_prime_flag (out_prime_flag)
);

/* bench/tb_trial_division_prime_test.sv */
module tb_trial_division_prime_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = 32;
  localparam int MaxReported = 10;
  localparam int DrainCycles = 8;
  localparam int TimeoutCycles = 5_000_000;

  typedef logic signed [DATA_WIDTH-1:0] candidate_t;

  // One pending answer, kept with its candidate for the error report.
  typedef struct packed {
    candidate_t candidate;
    logic       prime_flag;
  } primality_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  candidate_t in_candidate = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_prime_flag;

  primality_t pending_answers[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         out_stall_pct = 0;

  trial_division_prime_test #(
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_candidate  (in_candidate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prime_flag(out_prime_flag)
  );

  always #6 clk = ~clk;

  // Trial division up to the square root; negatives, zero and one are not prime.
  function automatic logic trial_division_flag(input candidate_t candidate);
    longint unsigned value;
    longint unsigned divisor;
    if (candidate < 0) return 1'b0;
    value = longint'(candidate);
    if (value <= 1) return 1'b0;
    if (value == 2) return 1'b1;
    if (value[0] == 1'b0) return 1'b0;
    for (divisor = 3; divisor <= value / divisor; divisor += 2) begin
      if (value % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly small values so the search stays short, plus full-width negatives,
  // large even values and large composites with a small odd factor.
  function automatic candidate_t random_candidate();
    int unsigned     pick;
    int unsigned     factor;
    longint unsigned product;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return candidate_t'($urandom_range(4095));
    end else if (pick < 55) begin
      return candidate_t'($urandom_range(65535));
    end else if (pick < 75) begin
      return {1'b1, 31'($urandom)};
    end else if (pick < 85) begin
      return {1'b0, 30'($urandom), 1'b0};
    end else begin
      factor = 2 * $urandom_range(50, 1) + 1;
      product = longint'(factor) * $urandom_range(32'h7FFF_FFFF / factor, 2);
      return candidate_t'(product[DATA_WIDTH-1:0]);
    end
  endfunction

  // Count an error and describe the first few of them.
  function automatic void report_error(input string what, input candidate_t candidate,
                                       input logic expected_flag, input logic actual_flag);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("[%0t] %s: candidate %0d expected prime_flag %b got %b",
               $realtime, what, candidate, expected_flag, actual_flag);
    end
  endfunction

  // Random stall on the result side and the check of every result transfer.
  always @(posedge clk) begin
    primality_t oldest;
    out_stall <= ($urandom_range(99) < out_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_error("unexpected result", '0, 1'bx, out_prime_flag);
      end else begin
        oldest = pending_answers.pop_front();
        if (out_prime_flag !== oldest.prime_flag) begin
          report_error("prime_flag mismatch", oldest.candidate, oldest.prime_flag,
                       out_prime_flag);
        end
      end
    end
  end

  // Offer one candidate after a random gap and record its answer on transfer.
  task automatic send_candidate(input candidate_t candidate);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_candidate <= candidate;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back('{candidate: candidate,
                                prime_flag: trial_division_flag(candidate)});
  endtask

  // Hold the input side quiet until every pending answer has come back.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Negatives, zero, one, two and even values.
  task automatic test_trivial_values();
    send_candidate(candidate_t'(32'h8000_0000));
    send_candidate(-1);
    send_candidate(-7);
    send_candidate(0);
    send_candidate(1);
    send_candidate(2);
    send_candidate(4);
    send_candidate(65536);
    send_candidate(32'h7FFF_FFFE);
  endtask

  // Odd values, with squares of primes where the last divisor tried is the root.
  task automatic test_odd_values();
    send_candidate(3);
    send_candidate(5);
    send_candidate(9);
    send_candidate(15);
    send_candidate(25);
    send_candidate(49);
    send_candidate(121);
    send_candidate(63001);
    send_candidate(65521);
    send_candidate(32'h7FFF_FFFD);
  endtask

  // The largest positive value is prime and needs the longest search.
  task automatic test_largest_prime();
    wait_for_answers();
    send_candidate(32'h7FFF_FFFF);
    wait_for_answers();
  endtask

  // Random candidates under one setting of input idling and result stalls.
  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (count) send_candidate(random_candidate());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_trivial_values();
    test_odd_values();
    test_largest_prime();
    test_random(25, 0, 0);
    test_random(25, 54, 0);
    test_random(25, 0, 54);
    test_random(25, 16, 16);

    // Let the last answers arrive, then leave room for anything stray.
    wait_for_answers();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a block that stops answering.
  initial begin
    repeat (TimeoutCycles) @(posedge clk);
    $display("timeout with %0d answers pending", pending_answers.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
